// ===== rtl/core/kdst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdst_pkg
// Shared sizes, operation and status codes, and the command and status
// structs that join the keyed deque controller to its datapath.
// ----------------------------------------------------------------------------
package kdst_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;
    localparam int RIDX_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [FUNC_W-1:0] F_PUSH_FRONT  = 3'd0;
    localparam logic [FUNC_W-1:0] F_PUSH_BACK   = 3'd1;
    localparam logic [FUNC_W-1:0] F_POP_FRONT   = 3'd2;
    localparam logic [FUNC_W-1:0] F_POP_BACK    = 3'd3;
    localparam logic [FUNC_W-1:0] F_ERASE       = 3'd4;
    localparam logic [FUNC_W-1:0] F_INSERT      = 3'd5;
    localparam logic [FUNC_W-1:0] F_SORT        = 3'd6;
    localparam logic [FUNC_W-1:0] F_READ        = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOKEY = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd4;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_START,
        OP_PTR_LIM,
        OP_RD_PTR,
        OP_RD_PTR_M1,
        OP_RD_PTR_P1,
        OP_RD_I,
        OP_RD_IDX,
        OP_SCAN_NEXT,
        OP_SR_INIT,
        OP_MOVE_DN,
        OP_MOVE_UP,
        OP_PUT,
        OP_SORT_LOAD,
        OP_SORT_NEXT,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [STAT_W-1:0]   status;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                give_read;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic                full;
        logic                empty;
        logic                idx_ok;
        logic                ptr_eq_lim;
        logic                ptr_eq_pos;
        logic                ptr_last;
        logic                hit;
        logic                sort_end;
        logic                out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/kdst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdst_dp
// Datapath: key/value memory with one read and one write port, entry count,
// walk pointers, the staged entry and the output word register.
// ----------------------------------------------------------------------------
module kdst_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  kdst_pkg::dp_cmd_t                   cmd,
    output kdst_pkg::dp_stat_t                  stat,
    input  logic [kdst_pkg::FUNC_W-1:0]         func,
    input  logic signed [kdst_pkg::DATA_W-1:0]  key_in,
    input  logic signed [kdst_pkg::DATA_W-1:0]  value_in,
    input  logic [kdst_pkg::RIDX_W-1:0]         read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kdst_pkg::STAT_W-1:0]         status,
    output logic [kdst_pkg::COUNT_W-1:0]        count,
    output logic signed [kdst_pkg::DATA_W-1:0]  read_key,
    output logic signed [kdst_pkg::DATA_W-1:0]  read_value
);
    import kdst_pkg::*;

    logic [DATA_W-1:0] key_mem [DEPTH];
    logic [DATA_W-1:0] val_mem [DEPTH];

    logic [DATA_W-1:0] rd_key_reg;
    logic [DATA_W-1:0] rd_val_reg;
    logic [DATA_W-1:0] tmp_key_reg;
    logic [DATA_W-1:0] tmp_val_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [RIDX_W-1:0] idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  i_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DATA_W-1:0] read_key_reg;
    logic [DATA_W-1:0] read_val_reg;

    logic              we;
    logic              re;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] wkey;
    logic [DATA_W-1:0] wval;
    logic [CNT_W:0]    ptr_p1;

    assign ptr_p1 = {1'b0, ptr_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = ptr_reg[IDX_W-1:0];
        raddr = ptr_reg[IDX_W-1:0];
        wkey  = rd_key_reg;
        wval  = rd_val_reg;
        unique case (cmd.op)
            OP_RD_PTR:
            begin
                re = 1'b1;
            end
            OP_RD_PTR_M1:
            begin
                re    = 1'b1;
                raddr = IDX_W'(ptr_reg - CNT_W'(1));
            end
            OP_RD_PTR_P1:
            begin
                re    = 1'b1;
                raddr = IDX_W'(ptr_p1);
            end
            OP_RD_I:
            begin
                re    = 1'b1;
                raddr = i_reg[IDX_W-1:0];
            end
            OP_RD_IDX:
            begin
                re    = 1'b1;
                raddr = IDX_W'(idx_reg);
            end
            OP_MOVE_DN, OP_MOVE_UP:
            begin
                we = 1'b1;
            end
            OP_PUT:
            begin
                we    = 1'b1;
                waddr = pos_reg[IDX_W-1:0];
                wkey  = tmp_key_reg;
                wval  = tmp_val_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
        if (re)
        begin
            rd_key_reg <= key_mem[raddr];
            rd_val_reg <= val_mem[raddr];
        end
    end

    // walk pointers and staged entry
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_START:
            begin
                func_reg    <= func;
                tmp_key_reg <= key_in;
                tmp_val_reg <= value_in;
                idx_reg     <= read_index;
                ptr_reg     <= '0;
                lim_reg     <= cnt_reg;
                i_reg       <= CNT_W'(1);
            end
            OP_PTR_LIM:
            begin
                ptr_reg <= lim_reg;
            end
            OP_SCAN_NEXT, OP_MOVE_UP:
            begin
                ptr_reg <= CNT_W'(ptr_p1);
            end
            OP_SR_INIT:
            begin
                pos_reg <= ptr_reg;
                ptr_reg <= lim_reg;
            end
            OP_MOVE_DN:
            begin
                ptr_reg <= ptr_reg - CNT_W'(1);
            end
            OP_SORT_LOAD:
            begin
                tmp_key_reg <= rd_key_reg;
                tmp_val_reg <= rd_val_reg;
                lim_reg     <= i_reg;
                ptr_reg     <= '0;
            end
            OP_SORT_NEXT:
            begin
                i_reg <= i_reg + CNT_W'(1);
            end
            default:
            begin
                ptr_reg <= ptr_reg;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            status_reg   <= cmd.status;
            count_reg    <= COUNT_W'(cnt_next);
            read_key_reg <= cmd.give_read ? rd_key_reg : '0;
            read_val_reg <= cmd.give_read ? rd_val_reg : '0;
        end
    end

    assign stat.func       = func_reg;
    assign stat.full       = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.idx_ok     = (32'(idx_reg) < 32'(cnt_reg));
    assign stat.ptr_eq_lim = (ptr_reg == lim_reg);
    assign stat.ptr_eq_pos = (ptr_reg == pos_reg);
    assign stat.ptr_last   = (ptr_p1 >= {1'b0, lim_reg});
    assign stat.hit        = (func_reg == F_ERASE) ? (rd_key_reg == tmp_key_reg)
                           : !($signed(rd_key_reg) < $signed(tmp_key_reg));
    assign stat.sort_end   = (i_reg >= cnt_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign read_key   = read_key_reg;
    assign read_value = read_val_reg;

endmodule

// ===== rtl/core/kdst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdst_ctrl
// Controller: sequences scans, shifts, insertion sort passes and reads
// through the datapath, one operation at a time.
// ----------------------------------------------------------------------------
module kdst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kdst_pkg::dp_stat_t  stat,
    output kdst_pkg::dp_cmd_t   cmd
);
    import kdst_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_SCAN_EV   = 4'd3;
    localparam logic [3:0] S_SR_INIT   = 4'd4;
    localparam logic [3:0] S_SR        = 4'd5;
    localparam logic [3:0] S_SR_MV     = 4'd6;
    localparam logic [3:0] S_SL        = 4'd7;
    localparam logic [3:0] S_SL_MV     = 4'd8;
    localparam logic [3:0] S_SORT_CHK  = 4'd9;
    localparam logic [3:0] S_SORT_LD   = 4'd10;
    localparam logic [3:0] S_SORT_NEXT = 4'd11;
    localparam logic [3:0] S_RD_WAIT   = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [STAT_W-1:0] st_reg;
    logic [STAT_W-1:0] st_next;
    logic              inc_reg;
    logic              inc_next;
    logic              dec_reg;
    logic              dec_next;
    logic              rdres_reg;
    logic              rdres_next;
    logic              is_sort;

    assign is_sort  = (stat.func == F_SORT);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        inc_next      = inc_reg;
        dec_next      = dec_reg;
        rdres_next    = rdres_reg;
        cmd.op        = OP_IDLE;
        cmd.status    = st_reg;
        cmd.cnt_inc   = 1'b0;
        cmd.cnt_dec   = 1'b0;
        cmd.give_read = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_START;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                st_next    = ST_OK;
                inc_next   = 1'b0;
                dec_next   = 1'b0;
                rdres_next = 1'b0;
                unique case (stat.func)
                    F_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            inc_next   = 1'b1;
                            state_next = S_SR_INIT;
                        end
                    end
                    F_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_PTR_LIM;
                            inc_next   = 1'b1;
                            state_next = S_SR_INIT;
                        end
                    end
                    F_INSERT:
                    begin
                        if (stat.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            inc_next   = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    F_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            dec_next   = 1'b1;
                            state_next = S_SL;
                        end
                    end
                    F_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            dec_next = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    F_ERASE:
                    begin
                        state_next = S_SCAN;
                    end
                    F_SORT:
                    begin
                        state_next = S_SORT_CHK;
                    end
                    F_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.op     = OP_RD_IDX;
                            rdres_next = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.ptr_eq_lim)
                begin
                    if (stat.func == F_ERASE)
                    begin
                        st_next    = ST_NOKEY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SR_INIT;
                    end
                end
                else
                begin
                    cmd.op     = OP_RD_PTR;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (stat.hit)
                begin
                    if (stat.func == F_ERASE)
                    begin
                        dec_next   = 1'b1;
                        state_next = S_SL;
                    end
                    else
                    begin
                        state_next = S_SR_INIT;
                    end
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN;
                end
            end
            S_SR_INIT:
            begin
                cmd.op     = OP_SR_INIT;
                state_next = S_SR;
            end
            S_SR:
            begin
                if (stat.ptr_eq_pos)
                begin
                    cmd.op     = OP_PUT;
                    state_next = is_sort ? S_SORT_NEXT : S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_PTR_M1;
                    state_next = S_SR_MV;
                end
            end
            S_SR_MV:
            begin
                cmd.op     = OP_MOVE_DN;
                state_next = S_SR;
            end
            S_SL:
            begin
                if (stat.ptr_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_PTR_P1;
                    state_next = S_SL_MV;
                end
            end
            S_SL_MV:
            begin
                cmd.op     = OP_MOVE_UP;
                state_next = S_SL;
            end
            S_SORT_CHK:
            begin
                if (stat.sort_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_I;
                    state_next = S_SORT_LD;
                end
            end
            S_SORT_LD:
            begin
                cmd.op     = OP_SORT_LOAD;
                state_next = S_SCAN;
            end
            S_SORT_NEXT:
            begin
                cmd.op     = OP_SORT_NEXT;
                state_next = S_SORT_CHK;
            end
            S_RD_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op        = OP_FINISH;
                    cmd.cnt_inc   = inc_reg;
                    cmd.cnt_dec   = dec_reg;
                    cmd.give_read = rdres_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            inc_reg   <= 1'b0;
            dec_reg   <= 1'b0;
            rdres_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            inc_reg   <= inc_next;
            dec_reg   <= dec_next;
            rdres_reg <= rdres_next;
        end
    end

endmodule

// ===== rtl/core/keyed_deque_sorted_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_deque_sorted_table
// Packed table of up to DEPTH key/value entries with deque, erase, sorted
// insert, insertion sort and indexed read.
//
// Input word (func, key_in, value_in, read_index) is taken on in_valid and
// in_ready; one result word (status, count, read_key, read_value) follows on
// out_valid and out_ready. One operation runs at a time; in_ready is high
// only while the controller is idle.
// Push front, pop front, erase and sorted insert walk the held entries:
// each scan step reads one entry and then compares its key, and each
// entry move is a read on the single read port followed by a write on the
// single write port of the entry memory. A sort runs one insertion
// pass per entry after the first, each a scan and shift over the
// entries before it.
// The result sits in an output register; a new word is accepted while it
// waits, and the next result holds until out_ready frees that register.
// Reset empties the table; entry contents are left as they are.
// ----------------------------------------------------------------------------
module keyed_deque_sorted_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [kdst_pkg::FUNC_W-1:0]         func,
    input  logic signed [kdst_pkg::DATA_W-1:0]  key_in,
    input  logic signed [kdst_pkg::DATA_W-1:0]  value_in,
    input  logic [kdst_pkg::RIDX_W-1:0]         read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [kdst_pkg::STAT_W-1:0]         status,
    output logic [kdst_pkg::COUNT_W-1:0]        count,
    output logic signed [kdst_pkg::DATA_W-1:0]  read_key,
    output logic signed [kdst_pkg::DATA_W-1:0]  read_value
);
    import kdst_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kdst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kdst_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (func),
        .key_in     (key_in),
        .value_in   (value_in),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .count      (count),
        .read_key   (read_key),
        .read_value (read_value)
    );

endmodule
